### rtl/nnsm_pkg.sv
package nnsm_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int STRIDE_W   = 16;
    localparam int BPP_W      = 4;
    localparam int OFF_W      = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // pipelined restoring divider: numerator, divisor, saturating quotient
    localparam int DIV_NW  = 26;
    localparam int DIV_DW  = 14;
    localparam int DIV_QW  = 13;
    localparam int DIV_LAT = DIV_QW + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_SCALE_MODE,
        REG_SRC_STRIDE,
        REG_DST_STRIDE,
        REG_BYTES_PER_PIXEL
    } cfg_reg_t;

    // sideband carried alongside the size divider
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   num;
        logic [DIM_W-1:0]   den;
        logic [OFF_W-1:0]   dst_off;
    } side_a_t;

    // sideband carried alongside the coordinate divider
    typedef struct packed {
        logic             we;
        logic [OFF_W-1:0] dst_off;
    } side_b_t;

    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [OFF_W-1:0]   src_off;
        logic [OFF_W-1:0]   dst_off;
    } result_t;

    // zero reads as one, anything past the limit as the limit
    function automatic logic [DIM_W-1:0] dim_f(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

### rtl/nnsm_div.sv
module nnsm_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [nnsm_pkg::DIV_NW-1:0] num,
    input  logic [nnsm_pkg::DIV_DW-1:0] den,
    output logic [nnsm_pkg::DIV_QW-1:0] quo
);
    import nnsm_pkg::*;

    logic [DIV_NW-1:0] rem_reg [0:DIV_QW-1];
    logic [DIV_DW-1:0] den_reg [0:DIV_QW-1];
    logic [DIV_QW-1:0] q_reg   [0:DIV_QW];
    logic              sat_reg [0:DIV_QW];

    logic [DIV_NW:0] top_w;
    logic            sat_next;

    // quotient does not fit: report all ones
    assign top_w    = (DIV_NW+1)'({den, {DIV_QW{1'b0}}});
    assign sat_next = {1'b0, num} >= top_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= DIV_QW; k++)
    begin : g_step
        localparam int B = DIV_QW - k;
        logic [DIV_NW:0] dsh;
        logic            ge;

        assign dsh = (DIV_NW+1)'(den_reg[k-1]) << B;
        assign ge  = {1'b0, rem_reg[k-1]} >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_reg[k-1] | ({{(DIV_QW-1){1'b0}}, ge} << B);
                sat_reg[k] <= sat_reg[k-1];
            end
        end

        if (k < DIV_QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - dsh[DIV_NW-1:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = sat_reg[DIV_QW] ? '1 : q_reg[DIV_QW];

endmodule

### rtl/nearest_neighbor_scale_mapper_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | dst_x, dst_y
// out      | out_valid/ out_ready | write_enable, src_x, src_y,
//          |                      | src_byte_offset, dst_byte_offset
// cfg      | cfg_write            | cfg_index, cfg_data (no read-back)
//
// One transaction per clock sustained while the output queue has room.
// Two 14-stage dividers lie in series: the first finds the
// scaled picture size (uniform mode), the second the source coordinate.
// Reset clears the valid bits and the output queue and sets the config registers to defaults.
// A two-entry output queue parts the sides: in_ready drops only when it is
// full, and the whole pipeline holds then, losing nothing.
module nearest_neighbor_scale_mapper_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [nnsm_pkg::COORD_W-1:0]    dst_x,
    input  logic [nnsm_pkg::COORD_W-1:0]    dst_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            write_enable,
    output logic [nnsm_pkg::COORD_W-1:0]    src_x,
    output logic [nnsm_pkg::COORD_W-1:0]    src_y,
    output logic [nnsm_pkg::OFF_W-1:0]      src_byte_offset,
    output logic [nnsm_pkg::OFF_W-1:0]      dst_byte_offset,
    input  logic                            cfg_write,
    input  logic [nnsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nnsm_pkg::*;

    localparam int NST = 2 * DIV_LAT + 12;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]    src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic                scale_mode_reg;
    logic [STRIDE_W-1:0] src_stride_reg, dst_stride_reg;
    logic [BPP_W-1:0]    bpp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
            dst_width_reg  <= DIM_W'(1);
            dst_height_reg <= DIM_W'(1);
            scale_mode_reg <= 1'b0;
            src_stride_reg <= '0;
            dst_stride_reg <= '0;
            bpp_reg        <= BPP_W'(4);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:       src_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:      src_height_reg <= cfg_data[DIM_W-1:0];
                REG_DST_WIDTH:       dst_width_reg  <= cfg_data[DIM_W-1:0];
                REG_DST_HEIGHT:      dst_height_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE_MODE:      scale_mode_reg <= cfg_data[0];
                REG_SRC_STRIDE:      src_stride_reg <= cfg_data;
                REG_DST_STRIDE:      dst_stride_reg <= cfg_data;
                REG_BYTES_PER_PIXEL: bpp_reg        <= cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes. Config only changes while nothing is in flight (the user must keep
    // to this; the block does not enforce it), so every stage may read these directly.
    logic [DIM_W-1:0] sw, sh, dw, dh, sw_m1, sh_m1;
    assign sw    = dim_f(src_width_reg);
    assign sh    = dim_f(src_height_reg);
    assign dw    = dim_f(dst_width_reg);
    assign dh    = dim_f(dst_height_reg);
    assign sw_m1 = sw - DIM_W'(1);
    assign sh_m1 = sh - DIM_W'(1);

    // ---------------- flow control ----------------
    logic [1:0]     cnt_reg;
    logic           adv;
    logic [NST-1:0] v_reg;

    assign adv      = (cnt_reg != 2'd2);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // ---------------- front: ratio pick and destination offset ----------
    logic [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [2*DIM_W-1:0] pa2_reg, pb2_reg;
    logic [27:0]        dy2_reg;
    logic [15:0]        dx2_reg;
    logic [DIM_W-1:0]   num3_reg, den3_reg;
    logic [OFF_W-1:0]   doff3_reg;
    logic [24:0]        mw4_reg, mh4_reg;
    side_a_t            side4_reg, side5_reg;
    logic [DIV_NW-1:0]  nw5_reg, nh5_reg;
    logic [DIV_DW-1:0]  dd5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= dst_x;
            y1_reg <= dst_y;

            pa2_reg <= (2*DIM_W)'(dh) * (2*DIM_W)'(sw);
            pb2_reg <= (2*DIM_W)'(dw) * (2*DIM_W)'(sh);
            dy2_reg <= 28'(y1_reg) * 28'(dst_stride_reg);
            dx2_reg <= 16'(x1_reg) * 16'(bpp_reg);
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;

            // height-limited when dh/sh is the smaller ratio
            num3_reg  <= (pa2_reg < pb2_reg) ? dh : dw;
            den3_reg  <= (pa2_reg < pb2_reg) ? sh : sw;
            doff3_reg <= OFF_W'(dy2_reg) + OFF_W'(dx2_reg);
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;

            mw4_reg           <= 25'(sw) * 25'(num3_reg);
            mh4_reg           <= 25'(sh) * 25'(num3_reg);
            side4_reg.x       <= x3_reg;
            side4_reg.y       <= y3_reg;
            side4_reg.num     <= num3_reg;
            side4_reg.den     <= den3_reg;
            side4_reg.dst_off <= doff3_reg;

            // round half up: (2*a*num + den) / (2*den)
            nw5_reg   <= {mw4_reg, 1'b0} + DIV_NW'(side4_reg.den);
            nh5_reg   <= {mh4_reg, 1'b0} + DIV_NW'(side4_reg.den);
            dd5_reg   <= {side4_reg.den, 1'b0};
            side5_reg <= side4_reg;
        end
    end

    // ---------------- scaled picture size ----------------
    logic [DIV_QW-1:0] w2, h2;
    side_a_t           sa_reg [0:DIV_LAT-1];

    nnsm_div u_div_w (.clk(clk), .en(adv), .num(nw5_reg), .den(dd5_reg), .quo(w2));
    nnsm_div u_div_h (.clk(clk), .en(adv), .num(nh5_reg), .den(dd5_reg), .quo(h2));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg[0] <= side5_reg;
            for (int k = 1; k < DIV_LAT; k++)
                sa_reg[k] <= sa_reg[k-1];
        end
    end

    // ---------------- centering, window test, operand select ----------------
    side_a_t            su1_reg;
    logic [COORD_W-1:0] ox1_reg, oy1_reg;
    logic               we2_reg, we3_reg;
    logic [COORD_W-1:0] ax2_reg, ay2_reg;
    logic [DIM_W-1:0]   fx2_reg, fy2_reg, cx2_reg, cy2_reg, cx3_reg, cy3_reg;
    logic [OFF_W-1:0]   doff2_reg, doff3b_reg;
    logic [24:0]        mx3_reg, my3_reg;
    logic [DIV_NW-1:0]  nx4_reg, ny4_reg;
    logic [DIV_DW-1:0]  ddx4_reg, ddy4_reg;
    side_b_t            sb4_reg;

    logic we_uni, we_str;
    assign we_uni = (su1_reg.x >= ox1_reg)
                 && ((DIM_W'(su1_reg.x) + DIM_W'(ox1_reg)) < dw)
                 && (su1_reg.y >= oy1_reg)
                 && ((DIM_W'(su1_reg.y) + DIM_W'(oy1_reg)) < dh);
    assign we_str = (DIM_W'(su1_reg.x) < dw) && (DIM_W'(su1_reg.y) < dh);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            su1_reg <= sa_reg[DIV_LAT-1];
            ox1_reg <= (w2 < dw) ? COORD_W'((dw - w2) >> 1) : '0;
            oy1_reg <= (h2 < dh) ? COORD_W'((dh - h2) >> 1) : '0;

            we2_reg   <= scale_mode_reg ? we_str : we_uni;
            ax2_reg   <= scale_mode_reg ? su1_reg.x : su1_reg.x - ox1_reg;
            ay2_reg   <= scale_mode_reg ? su1_reg.y : su1_reg.y - oy1_reg;
            fx2_reg   <= scale_mode_reg ? sw : su1_reg.den;
            fy2_reg   <= scale_mode_reg ? sh : su1_reg.den;
            cx2_reg   <= scale_mode_reg ? dw : su1_reg.num;
            cy2_reg   <= scale_mode_reg ? dh : su1_reg.num;
            doff2_reg <= su1_reg.dst_off;

            mx3_reg    <= 25'(ax2_reg) * 25'(fx2_reg);
            my3_reg    <= 25'(ay2_reg) * 25'(fy2_reg);
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            we3_reg    <= we2_reg;
            doff3b_reg <= doff2_reg;

            nx4_reg         <= {mx3_reg, 1'b0} + DIV_NW'(cx3_reg);
            ny4_reg         <= {my3_reg, 1'b0} + DIV_NW'(cy3_reg);
            ddx4_reg        <= {cx3_reg, 1'b0};
            ddy4_reg        <= {cy3_reg, 1'b0};
            sb4_reg.we      <= we3_reg;
            sb4_reg.dst_off <= doff3b_reg;
        end
    end

    // ---------------- source coordinate ----------------
    logic [DIV_QW-1:0] qx, qy;
    side_b_t           sb_reg [0:DIV_LAT-1];

    nnsm_div u_div_x (.clk(clk), .en(adv), .num(nx4_reg), .den(ddx4_reg), .quo(qx));
    nnsm_div u_div_y (.clk(clk), .en(adv), .num(ny4_reg), .den(ddy4_reg), .quo(qy));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= sb4_reg;
            for (int k = 1; k < DIV_LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // ---------------- clamp and source offset ----------------
    side_b_t            sr1_reg;
    logic [COORD_W-1:0] sx1_reg, sy1_reg;
    logic [27:0]        psy2_reg;
    logic [15:0]        psx2_reg;
    result_t            r2_reg, r3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr1_reg <= sb_reg[DIV_LAT-1];
            // clamp to the last column/row; unwritten pixels report zero
            if (sb_reg[DIV_LAT-1].we)
            begin
                sx1_reg <= (qx > sw_m1) ? sw_m1[COORD_W-1:0] : qx[COORD_W-1:0];
                sy1_reg <= (qy > sh_m1) ? sh_m1[COORD_W-1:0] : qy[COORD_W-1:0];
            end
            else
            begin
                sx1_reg <= '0;
                sy1_reg <= '0;
            end

            psy2_reg       <= 28'(sy1_reg) * 28'(src_stride_reg);
            psx2_reg       <= 16'(sx1_reg) * 16'(bpp_reg);
            r2_reg.we      <= sr1_reg.we;
            r2_reg.src_x   <= sx1_reg;
            r2_reg.src_y   <= sy1_reg;
            r2_reg.src_off <= '0;
            r2_reg.dst_off <= sr1_reg.dst_off;

            r3_reg.we      <= r2_reg.we;
            r3_reg.src_x   <= r2_reg.src_x;
            r3_reg.src_y   <= r2_reg.src_y;
            r3_reg.src_off <= OFF_W'(psy2_reg) + OFF_W'(psx2_reg);
            r3_reg.dst_off <= r2_reg.dst_off;
        end
    end

    // ---------------- output queue ----------------
    result_t buf_reg [0:1];
    logic    wr_ptr_reg, rd_ptr_reg;
    logic    push, pop;

    assign push = adv && v_reg[NST-1];
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= r3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    assign out_valid       = (cnt_reg != 2'd0);
    assign write_enable    = buf_reg[rd_ptr_reg].we;
    assign src_x           = buf_reg[rd_ptr_reg].src_x;
    assign src_y           = buf_reg[rd_ptr_reg].src_y;
    assign src_byte_offset = buf_reg[rd_ptr_reg].src_off;
    assign dst_byte_offset = buf_reg[rd_ptr_reg].dst_off;

endmodule

### rtl/nnsm_checker.sv
module nnsm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         write_enable,
    input logic [nnsm_pkg::COORD_W-1:0] src_x,
    input logic [nnsm_pkg::COORD_W-1:0] src_y,
    input logic [nnsm_pkg::OFF_W-1:0]   src_byte_offset
);
    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(src_x) && $stable(src_y)
            && $stable(src_byte_offset) && $stable(write_enable))
        else $error("output changed while stalled");

    // skipped pixel carries no source
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> src_x == '0 && src_y == '0
            && src_byte_offset == '0)
        else $error("skipped pixel has nonzero source fields");

    // input backpressure only with results waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind nearest_neighbor_scale_mapper_top nnsm_checker u_nnsm_checker (.*);

### sim/tb_nearest_neighbor_scale_mapper_top.sv
`timescale 1ns / 100ps

// Scoreboard: predicts the mapping of each accepted coordinate and checks results in order.
class scale_map_scoreboard;
    bit [12:0] src_w, src_h, dst_w, dst_h;
    bit        stretch;
    bit [15:0] src_stride_r, dst_stride_r;
    bit [3:0]  bpp;
    bit [0:0]  exp_we[$];
    bit [11:0] exp_sx[$], exp_sy[$];
    bit [28:0] exp_soff[$], exp_doff[$];
    int        errors;
    int        checked;
    int        written;

    function void reset_regs();
        src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
        stretch = 0; src_stride_r = 0; dst_stride_r = 0; bpp = 4;
    endfunction

    function void write_reg(nnsm_pkg::cfg_reg_t idx, bit [15:0] val);
        case (idx)
            nnsm_pkg::REG_SRC_WIDTH:       src_w = val[12:0];
            nnsm_pkg::REG_SRC_HEIGHT:      src_h = val[12:0];
            nnsm_pkg::REG_DST_WIDTH:       dst_w = val[12:0];
            nnsm_pkg::REG_DST_HEIGHT:      dst_h = val[12:0];
            nnsm_pkg::REG_SCALE_MODE:      stretch = val[0];
            nnsm_pkg::REG_SRC_STRIDE:      src_stride_r = val;
            nnsm_pkg::REG_DST_STRIDE:      dst_stride_r = val;
            nnsm_pkg::REG_BYTES_PER_PIXEL: bpp = val[3:0];
            default: ;
        endcase
    endfunction

    function longint unsigned clip_dim(bit [12:0] v);
        if (v == 0)
            return 1;
        if (v > nnsm_pkg::MAX_DIM)
            return nnsm_pkg::MAX_DIM;
        return v;
    endfunction

    function longint unsigned rnd(longint unsigned a, longint unsigned n,
                                  longint unsigned d);
        return (2 * a * n + d) / (2 * d);
    endfunction

    function void note_coord(bit [11:0] x, bit [11:0] y);
        longint unsigned sw, sh, dw, dh, sx, sy, num, den, w2, h2, ox, oy;
        bit we;
        sw = clip_dim(src_w); sh = clip_dim(src_h);
        dw = clip_dim(dst_w); dh = clip_dim(dst_h);
        sx = 0; sy = 0;
        if (stretch) begin
            we = x < dw && y < dh;
            if (we) begin
                sx = rnd(x, sw, dw);
                sy = rnd(y, sh, dh);
            end
        end else begin
            if (dh * sw < dw * sh) begin
                num = dh; den = sh;
            end else begin
                num = dw; den = sw;
            end
            w2 = rnd(sw, num, den);
            h2 = rnd(sh, num, den);
            ox = w2 < dw ? (dw - w2) / 2 : 0;
            oy = h2 < dh ? (dh - h2) / 2 : 0;
            we = x >= ox && x + ox < dw && y >= oy && y + oy < dh;
            if (we) begin
                sx = rnd(x - ox, den, num);
                sy = rnd(y - oy, den, num);
            end
        end
        if (we) begin
            if (sx > sw - 1) sx = sw - 1;
            if (sy > sh - 1) sy = sh - 1;
        end
        exp_we.push_back(we);
        exp_sx.push_back(sx[11:0]);
        exp_sy.push_back(sy[11:0]);
        exp_soff.push_back(we ? 29'(sy * src_stride_r + sx * bpp) : 29'd0);
        exp_doff.push_back(29'(longint'(y) * dst_stride_r + longint'(x) * bpp));
    endfunction

    function int pending();
        return exp_we.size();
    endfunction
endclass

module tb_nearest_neighbor_scale_mapper_top;
    import nnsm_pkg::*;

    localparam int N_RANDOM   = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;   // beyond the pipeline depth

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [COORD_W-1:0] dst_x = '0;
    logic [COORD_W-1:0] dst_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic write_enable;
    logic [COORD_W-1:0] src_x, src_y;
    logic [OFF_W-1:0] src_byte_offset, dst_byte_offset;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    scale_map_scoreboard sb;
    int cycles = 0;
    int n_sent = 0;
    int n_phases = 0;
    bit stall_mode = 0;   // receiver pattern selector

    nearest_neighbor_scale_mapper_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .dst_x(dst_x), .dst_y(dst_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .write_enable(write_enable), .src_x(src_x), .src_y(src_y),
        .src_byte_offset(src_byte_offset), .dst_byte_offset(dst_byte_offset),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report(string what, longint unsigned got, longint unsigned want);
        sb.errors++;
        if (sb.errors <= 30)
            $display("mismatch #%0d %s: got %0h want %0h", sb.checked, what, got, want);
    endtask

    // check every output transaction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sb.pending() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                if (write_enable !== sb.exp_we[0])
                    report("write_enable", write_enable, sb.exp_we[0]);
                if (src_x !== sb.exp_sx[0]) report("src_x", src_x, sb.exp_sx[0]);
                if (src_y !== sb.exp_sy[0]) report("src_y", src_y, sb.exp_sy[0]);
                if (src_byte_offset !== sb.exp_soff[0])
                    report("src_byte_offset", src_byte_offset, sb.exp_soff[0]);
                if (dst_byte_offset !== sb.exp_doff[0])
                    report("dst_byte_offset", dst_byte_offset, sb.exp_doff[0]);
                if (sb.exp_we[0]) sb.written++;
                void'(sb.exp_we.pop_front());
                void'(sb.exp_sx.pop_front());
                void'(sb.exp_sy.pop_front());
                void'(sb.exp_soff.pop_front());
                void'(sb.exp_doff.pop_front());
            end
            sb.checked++;
        end
    end

    // receiver: either random stalls or long ready stretches, chosen per phase
    always @(negedge clk)
    begin
        if (stall_mode)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 15) != 0) || (cycles % 64 > 40);
    end

    task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // one transaction; called on a falling edge, returns on a falling edge
    task automatic send_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        in_valid <= 1'b1;
        dst_x <= x;
        dst_y <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_coord(x, y);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic idle_in(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // wait for all results, then the pipeline depth for safety
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_all(int sw, int sh, int dw, int dh, bit mode,
                           int ss, int ds, int bp);
        write_cfg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
        write_cfg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
        write_cfg(REG_DST_WIDTH, CFG_DATA_W'(dw));
        write_cfg(REG_DST_HEIGHT, CFG_DATA_W'(dh));
        write_cfg(REG_SCALE_MODE, CFG_DATA_W'(mode));
        write_cfg(REG_SRC_STRIDE, CFG_DATA_W'(ss));
        write_cfg(REG_DST_STRIDE, CFG_DATA_W'(ds));
        write_cfg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(bp));
        n_phases++;
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 8191);      // includes 0 and past the limit
        if (r == 1) return $urandom_range(4090, 4096);
        if (r < 5) return $urandom_range(1, 8);
        return $urandom_range(1, 300);
    endfunction

    // coordinates mostly inside or around the destination box
    function automatic logic [COORD_W-1:0] pick_coord(int d);
        int lim;
        lim = (d == 0) ? 1 : (d > 4096 ? 4096 : d);
        if ($urandom_range(0, 9) == 0)
            return COORD_W'($urandom_range(0, 4095));
        return COORD_W'($urandom_range(0, (lim + 2 > 4095) ? 4095 : lim + 1));
    endfunction

    task automatic random_phase(int n_items);
        int burst;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < n_items)
            begin
                send_coord(pick_coord(sb.dst_w), pick_coord(sb.dst_h));
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_in($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults straight out of reset
        send_coord(0, 0);
        send_coord(12'hFFF, 12'hFFF);
        drain();

        // uniform, wide destination with centering; odd pixel size and zero
        set_all(3, 2, 7, 2, 1'b0, 16'hFFFF, 16'hFFFF, 15);
        send_coord(0, 0);
        send_coord(1, 1);
        send_coord(6, 1);
        send_coord(3, 0);
        send_coord(12'hFFF, 12'hFFF);
        drain();
        write_cfg(REG_BYTES_PER_PIXEL, 16'd0);
        send_coord(5, 1);
        send_coord(12'hAAA, 12'h555);
        drain();

        // stretch: edge clamp, outside the destination, max dims and strides
        set_all(4096, 4096, 4096, 4096, 1'b1, 16'hFFFF, 16'hFFFF, 8);
        send_coord(12'hFFF, 12'hFFF);
        send_coord(0, 12'hFFF);
        send_coord(12'h555, 12'hAAA);
        drain();
        write_cfg(REG_DST_WIDTH, 16'd3);
        write_cfg(REG_DST_HEIGHT, 16'd8191);
        send_coord(2, 4095);
        send_coord(3, 0);
        drain();
        write_cfg(REG_SRC_WIDTH, 16'd0);
        write_cfg(REG_SRC_HEIGHT, 16'd5);
        send_coord(2, 7);
        send_coord(0, 0);
        drain();

        // equal sizes, uniform: identity
        set_all(9, 9, 9, 9, 1'b0, 40, 36, 4);
        send_coord(8, 8);
        send_coord(4, 0);
        send_coord(9, 3);
        drain();

        // random phases with fresh settings each time
        while (n_sent < N_RANDOM + 30)
        begin
            stall_mode = $urandom_range(0, 1);
            set_all(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                    1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 15));
            random_phase($urandom_range(60, 200));
            drain();
        end

        $display("covered %0d coordinates over %0d register settings, %0d written",
                 n_sent, n_phases, sb.written);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
